// ----- sv/necir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC infrared frame decoder: field widths,
// frame lengths, configuration register indexes and result status codes.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Field widths
  localparam int unsigned TimeW  = 15;
  localparam int unsigned TolW   = 10;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgAddrW = 3;

  // Frame layout: leader, data bits, stop symbol
  localparam int unsigned DataBits   = 32;
  localparam int unsigned BitIdxW    = $clog2(DataBits);
  localparam int unsigned FullFrame  = DataBits + 2;
  localparam int unsigned RepFrame   = 2;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_TOLERANCE    = 3'd0,
    CFG_LEADER_MARK  = 3'd1,
    CFG_LEADER_SPACE = 3'd2,
    CFG_BIT_MARK     = 3'd3,
    CFG_ZERO_SPACE   = 3'd4,
    CFG_ONE_SPACE    = 3'd5,
    CFG_REPEAT_SPACE = 3'd6
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_NEW_FRAME  = 2'd0,
    ST_REPEAT     = 2'd1,
    ST_BAD_TIMING = 2'd2,
    ST_BAD_COUNT  = 2'd3
  } status_e;

  // Register reset values
  localparam logic [TolW-1:0]  TolReset       = 10'd200;
  localparam logic [TimeW-1:0] LeaderMarkRst  = 15'd9000;
  localparam logic [TimeW-1:0] LeaderSpaceRst = 15'd4500;
  localparam logic [TimeW-1:0] BitMarkRst     = 15'd560;
  localparam logic [TimeW-1:0] ZeroSpaceRst   = 15'd560;
  localparam logic [TimeW-1:0] OneSpaceRst    = 15'd1690;
  localparam logic [TimeW-1:0] RepSpaceRst    = 15'd2250;

endpackage

// ----- sv/necir_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_window
// Duration window check: true when the measured time lies strictly between
// nominal - tolerance (clamped at zero) and nominal + tolerance.
// ----------------------------------------------------------------------------
module necir_window
  import necir_pkg::*;
(
  input  logic [TimeW-1:0] measured_i,
  input  logic [TimeW-1:0] nominal_i,
  input  logic [TolW-1:0]  tolerance_i,
  output logic             hit_o
);

  logic [TimeW:0] upper;
  logic [TimeW:0] lower;
  logic [TimeW:0] tol_ext;

  // Bounds, one bit wider so the upper sum cannot wrap
  always_comb begin
    tol_ext = {{(TimeW + 1 - TolW){1'b0}}, tolerance_i};
    upper   = {1'b0, nominal_i} + tol_ext;
    if ({1'b0, nominal_i} > tol_ext) begin
      lower = {1'b0, nominal_i} - tol_ext;
    end else begin
      lower = '0;
    end
    hit_o = ({1'b0, measured_i} < upper) && ({1'b0, measured_i} > lower);
  end

endmodule

// ----- sv/nec_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Path: an accepted symbol beat passes the input register, then the result
//   register; only frame-end symbols give a result.
// Throughput: one symbol per cycle, set by the single registered pass of the
//   window checks and frame-state update, while the result stream is not stalled.
// Reset: rst_ni clears pipeline valids, frame state, saved address/command,
//   and loads the timing registers with their NEC defaults.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
  import necir_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [TimeW-1:0]     cfg_wdata_i,
  // symbol stream in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [31:0]          s_axis_tdata_i,  // [14:0] mark_time, [29:15] space_time
  input  logic                 s_axis_tlast_i,  // frame_end
  // result stream out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,  // [15:0] address, [31:16] command
  output logic [StatW-1:0]     m_axis_tuser_o   // [1:0] status
);

  // Timing registers
  logic [TolW-1:0]  tol_q;
  logic [TimeW-1:0] ldr_mark_q, ldr_space_q, bit_mark_q;
  logic [TimeW-1:0] zero_space_q, one_space_q, rep_space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= TolReset;
      ldr_mark_q   <= LeaderMarkRst;
      ldr_space_q  <= LeaderSpaceRst;
      bit_mark_q   <= BitMarkRst;
      zero_space_q <= ZeroSpaceRst;
      one_space_q  <= OneSpaceRst;
      rep_space_q  <= RepSpaceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TOLERANCE:    tol_q        <= cfg_wdata_i[TolW-1:0];
        CFG_LEADER_MARK:  ldr_mark_q   <= cfg_wdata_i;
        CFG_LEADER_SPACE: ldr_space_q  <= cfg_wdata_i;
        CFG_BIT_MARK:     bit_mark_q   <= cfg_wdata_i;
        CFG_ZERO_SPACE:   zero_space_q <= cfg_wdata_i;
        CFG_ONE_SPACE:    one_space_q  <= cfg_wdata_i;
        CFG_REPEAT_SPACE: rep_space_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance, in_fire, proc;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign proc            = in_valid_q && advance;

  // Input register
  logic [TimeW-1:0] mark_q, space_q;
  logic             last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mark_q  <= s_axis_tdata_i[TimeW-1:0];
      space_q <= s_axis_tdata_i[2*TimeW-1:TimeW];
      last_q  <= s_axis_tlast_i;
    end
  end

  // Window checks on the registered symbol
  logic hit_lm, hit_ls, hit_rs, hit_bm, hit_one, hit_zero;

  necir_window u_win_lm (
    .measured_i(mark_q), .nominal_i(ldr_mark_q), .tolerance_i(tol_q), .hit_o(hit_lm)
  );
  necir_window u_win_ls (
    .measured_i(space_q), .nominal_i(ldr_space_q), .tolerance_i(tol_q), .hit_o(hit_ls)
  );
  necir_window u_win_rs (
    .measured_i(space_q), .nominal_i(rep_space_q), .tolerance_i(tol_q), .hit_o(hit_rs)
  );
  necir_window u_win_bm (
    .measured_i(mark_q), .nominal_i(bit_mark_q), .tolerance_i(tol_q), .hit_o(hit_bm)
  );
  necir_window u_win_one (
    .measured_i(space_q), .nominal_i(one_space_q), .tolerance_i(tol_q), .hit_o(hit_one)
  );
  necir_window u_win_zero (
    .measured_i(space_q), .nominal_i(zero_space_q), .tolerance_i(tol_q), .hit_o(hit_zero)
  );

  // Frame state
  logic [CountW-1:0]   count_q, count_d;
  logic [DataBits-1:0] shift_q, shift_d;
  logic                leader_ok_q, leader_ok_d;
  logic                repeat_ok_q, repeat_ok_d;
  logic                bits_ok_q, bits_ok_d;
  logic [HalfW-1:0]    saved_addr_q, saved_addr_d;
  logic [HalfW-1:0]    saved_cmd_q, saved_cmd_d;
  status_e             status_q, status_d;
  logic [BitIdxW-1:0]  bit_idx;
  logic                is_data;

  assign bit_idx = BitIdxW'(count_q - CountW'(1));
  assign is_data = (count_q != '0) && (count_q <= CountW'(DataBits));

  // Next frame state and result
  always_comb begin
    count_d      = count_q;
    shift_d      = shift_q;
    leader_ok_d  = leader_ok_q;
    repeat_ok_d  = repeat_ok_q;
    bits_ok_d    = bits_ok_q;
    saved_addr_d = saved_addr_q;
    saved_cmd_d  = saved_cmd_q;
    status_d     = status_q;
    if (proc) begin
      if (count_q == '0) begin
        leader_ok_d = hit_lm && hit_ls;
        repeat_ok_d = hit_lm && hit_rs;
      end else if (is_data) begin
        if (hit_bm && hit_one) begin
          shift_d[bit_idx] = 1'b1;
        end else if (!(hit_bm && hit_zero)) begin
          bits_ok_d = 1'b0;
        end
      end

      if (!last_q) begin
        if (count_q != '1) begin
          count_d = count_q + CountW'(1);
        end
      end else begin
        if (count_q == CountW'(FullFrame - 1)) begin
          if (leader_ok_d && bits_ok_d) begin
            saved_addr_d = shift_d[HalfW-1:0];
            saved_cmd_d  = shift_d[2*HalfW-1:HalfW];
            status_d     = ST_NEW_FRAME;
          end else begin
            status_d = ST_BAD_TIMING;
          end
        end else if (count_q == CountW'(RepFrame - 1)) begin
          status_d = repeat_ok_d ? ST_REPEAT : ST_BAD_TIMING;
        end else begin
          status_d = ST_BAD_COUNT;
        end
        // back to an empty frame
        count_d     = '0;
        shift_d     = '0;
        leader_ok_d = 1'b0;
        repeat_ok_d = 1'b0;
        bits_ok_d   = 1'b1;
      end
    end
  end

  // Result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      shift_q      <= '0;
      leader_ok_q  <= 1'b0;
      repeat_ok_q  <= 1'b0;
      bits_ok_q    <= 1'b1;
      saved_addr_q <= '0;
      saved_cmd_q  <= '0;
      status_q     <= ST_NEW_FRAME;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      shift_q      <= shift_d;
      leader_ok_q  <= leader_ok_d;
      repeat_ok_q  <= repeat_ok_d;
      bits_ok_q    <= bits_ok_d;
      saved_addr_q <= saved_addr_d;
      saved_cmd_q  <= saved_cmd_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result beat: saved values already hold this frame's update
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {saved_cmd_q, saved_addr_q};
  assign m_axis_tuser_o  = status_q;

endmodule
